// ===== src/websocket_text_frame_unmasker_top_defines.svh =====
// ----------------------------------------------------------------------------
// websocket text frame unmasker assertion macros
// shared property wrappers for the concurrent checks of the top level
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_TEXT_FRAME_UNMASKER_TOP_DEFINES_SVH
`define WEBSOCKET_TEXT_FRAME_UNMASKER_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define WTFU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define WTFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/wtfu_pkg.sv =====
// ----------------------------------------------------------------------------
// wtfu_pkg
// types and constants shared by the frame unmasker modules
// ----------------------------------------------------------------------------
package wtfu_pkg;

	localparam logic [7:0] HDR_FIN    = 8'h80;
	localparam logic [7:0] HDR_OPMASK = 8'h0F;
	localparam logic [7:0] HDR_OPTEXT = 8'h01;
	localparam logic [6:0] LEN_MAX    = 7'd125;
	localparam logic [1:0] KEY_LAST   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	typedef enum logic [4:0] {
		PH_HDR0 = 5'b00001,
		PH_HDR1 = 5'b00010,
		PH_KEY  = 5'b00100,
		PH_PAY  = 5'b01000,
		PH_SKIP = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       frame_last;
		logic [1:0] status;
	} res_t;

endpackage

// ===== src/wtfu_in_reg.sv =====
// ----------------------------------------------------------------------------
// wtfu_in_reg
// input register stage: holds one received byte until the parser takes it
// ----------------------------------------------------------------------------
module wtfu_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  wtfu_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output wtfu_pkg::item_t item_s1
);
	import wtfu_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== src/wtfu_parser.sv =====
// ----------------------------------------------------------------------------
// wtfu_parser
// frame header check, mask key capture and payload unmasking, one byte a step
// ----------------------------------------------------------------------------
module wtfu_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  wtfu_pkg::item_t item,
	output logic            res_vld,
	output wtfu_pkg::res_t  res
);
	import wtfu_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] key_q [4];
	logic [6:0] left_q, left_d;
	logic [1:0] idx_q, idx_d;
	logic       key_we;
	logic [6:0] len;
	logic [7:0] plain;
	logic       end_b;
	logic       hdr_bad;

	assign end_b   = item.buffer_end;
	assign len     = item.data_byte[6:0];
	assign plain   = item.data_byte ^ key_q[idx_q];
	assign hdr_bad = ((item.data_byte & HDR_FIN) != HDR_FIN) ||
		((item.data_byte & HDR_OPMASK) != HDR_OPTEXT);

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		idx_d   = idx_q;
		key_we  = 1'b0;
		res_vld = 1'b0;
		res     = '0;
		unique case (phase_q)
			PH_HDR0: begin
				if (hdr_bad) begin
					phase_d = end_b ? PH_HDR0 : PH_SKIP;
					res_vld = 1'b1;
					res     = '{8'd0, 1'b0, 1'b1, ST_BAD};
				end else if (end_b) begin
					phase_d = PH_HDR0;
					res_vld = 1'b1;
					res     = '{8'd0, 1'b0, 1'b1, ST_SHORT};
				end else begin
					phase_d = PH_HDR1;
				end
			end
			PH_HDR1: begin
				if (len > LEN_MAX) begin
					phase_d = end_b ? PH_HDR0 : PH_SKIP;
					res_vld = 1'b1;
					res     = '{8'd0, 1'b0, 1'b1, ST_BAD};
				end else begin
					left_d = len;
					idx_d  = 2'd0;
					if (end_b) begin
						phase_d = PH_HDR0;
						res_vld = 1'b1;
						res     = '{8'd0, 1'b0, 1'b1, ST_SHORT};
					end else begin
						phase_d = PH_KEY;
					end
				end
			end
			PH_KEY: begin
				key_we = 1'b1;
				if (idx_q == KEY_LAST) begin
					idx_d = 2'd0;
					if (left_q == 7'd0) begin
						// empty frame: one final result with no byte
						phase_d = end_b ? PH_HDR0 : PH_SKIP;
						res_vld = 1'b1;
						res     = '{8'd0, 1'b0, 1'b1, ST_OK};
					end else if (end_b) begin
						phase_d = PH_HDR0;
						res_vld = 1'b1;
						res     = '{8'd0, 1'b0, 1'b1, ST_SHORT};
					end else begin
						phase_d = PH_PAY;
					end
				end else begin
					idx_d = idx_q + 2'd1;
					if (end_b) begin
						phase_d = PH_HDR0;
						res_vld = 1'b1;
						res     = '{8'd0, 1'b0, 1'b1, ST_SHORT};
					end
				end
			end
			PH_PAY: begin
				res_vld = 1'b1;
				if (left_q <= 7'd1) begin
					left_d  = 7'd0;
					idx_d   = 2'd0;
					phase_d = end_b ? PH_HDR0 : PH_SKIP;
					res     = '{plain, 1'b1, 1'b1, ST_OK};
				end else if (end_b) begin
					phase_d = PH_HDR0;
					res     = '{8'd0, 1'b0, 1'b1, ST_SHORT};
				end else begin
					left_d = left_q - 7'd1;
					idx_d  = idx_q + 2'd1;
					res    = '{plain, 1'b1, 1'b0, ST_OK};
				end
			end
			default: begin
				// skip phase and stray codes: drop bytes until the buffer ends
				if (end_b) begin
					phase_d = PH_HDR0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			left_q  <= 7'd0;
			idx_q   <= 2'd0;
			key_q   <= '{default: 8'd0};
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			idx_q   <= idx_d;
			if (key_we) begin
				key_q[idx_q] <= item.data_byte;
			end
		end
	end

endmodule

// ===== src/wtfu_out_reg.sv =====
// ----------------------------------------------------------------------------
// wtfu_out_reg
// result register: holds one result until the downstream side takes it
// ----------------------------------------------------------------------------
module wtfu_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  wtfu_pkg::res_t res,
	input  logic           out_ready,
	output logic           out_valid,
	output logic           free,
	output wtfu_pkg::res_t res_s2
);
	import wtfu_pkg::*;

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== src/websocket_text_frame_unmasker_top.sv =====
// an accepted byte is held in the input register, then its result in the result register
// throughput: one byte per cycle, unless a byte with a result waits on a stalled result register
// bytes that give no result pass the parser even while the result register waits
// reset: arst_n low clears both stage valids and returns the parser to the first
// header byte with a zero mask key, zero length and zero key index
// ----------------------------------------------------------------------------
// websocket_text_frame_unmasker_top
// receives frame bytes, checks the text frame header and unmasks the payload
// ----------------------------------------------------------------------------
`include "websocket_text_frame_unmasker_top_defines.svh"

module websocket_text_frame_unmasker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast,
	output logic [2:0] m_axis_tuser   // [0] has_byte, [2:1] status
);
	import wtfu_pkg::*;

	item_t in_item;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	logic  res_vld;
	res_t  res;
	res_t  res_s2;
	logic  out_free;

	assign in_item = '{s_axis_tdata, s_axis_tlast};
	// an item without a result never needs the result register
	assign advance = valid_s1 && (!res_vld || out_free);

	wtfu_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wtfu_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	wtfu_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_vld),
		.res       (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.free      (out_free),
		.res_s2    (res_s2)
	);

	assign m_axis_tdata = res_s2.out_byte;
	assign m_axis_tlast = res_s2.frame_last;
	assign m_axis_tuser = {res_s2.status, res_s2.has_byte};

	`WTFU_ASSERT_IMPL(a_nobyte_final, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == 8'd0), "result without byte must be final and zero")
	`WTFU_ASSERT_IMPL(a_err_nobyte, clk, arst_n, m_axis_tvalid && (m_axis_tuser[2:1] != ST_OK), !m_axis_tuser[0] && (m_axis_tuser[2:1] != 2'd3), "error result carries a byte or bad status")
	`WTFU_ASSERT_IMPL(a_no_overwrite, clk, arst_n, m_axis_tvalid && !m_axis_tready, !(advance && res_vld), "result register overwritten while stalled")
	`WTFU_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, valid_s1 && res_vld && m_axis_tvalid && !m_axis_tready, valid_s1 && $stable(item_s1), "stalled byte lost from input stage")

endmodule
